@@ src/srgbtc_pkg.sv @@
// Shared constants, types and curve table builder functions for the sRGB transfer converter.
package srgbtc_pkg;

   localparam int CHANNEL_BITS_DEF        = 16;
   localparam int CURVE_TABLE_ENTRIES_DEF = 256;

   // Curve points are unsigned Q1.30 and never exceed a little over 1.0.
   localparam int ENTRY_BITS = 31;

   // Direction codes carried on the func field.
   localparam logic FUNC_TO_LINEAR = 1'b0;
   localparam logic FUNC_TO_SRGB   = 1'b1;

   typedef logic [63:0]           wide_type;
   typedef logic [ENTRY_BITS-1:0] entry_type;

   localparam wide_type ONE_Q30 = 64'd1 << 30;

   // Truncating Q2.30 product.
   function automatic wide_type q_mul(input wide_type a, input wide_type b);
      return (a * b) >> 30;
   endfunction

   // Integer power of a Q2.30 value.
   function automatic wide_type q_pow(input wide_type r, input int n);
      wide_type acc;
      acc = ONE_Q30;
      for (int i = 0; i < n; i++) begin
         acc = q_mul(acc, r);
      end
      return acc;
   endfunction

   // Largest r in [0, 1.0] whose n-th power does not exceed v, by bisection.
   function automatic wide_type q_root(input wide_type v, input int n);
      wide_type lo;
      wide_type hi;
      wide_type mid;
      lo = '0;
      hi = ONE_Q30;
      for (int i = 0; i < 32; i++) begin
         if (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (q_pow(mid, n) <= v) begin
               lo = mid;
            end else begin
               hi = mid - 64'd1;
            end
         end
      end
      return lo;
   endfunction

   // Decode curve point: ((x + 0.055) / 1.055) ^ 2.4.
   function automatic entry_type lin_entry(input wide_type x);
      wide_type a;
      wide_type s;
      a = (x * 64'd1000 + 64'd55 * ONE_Q30) / 64'd1055;
      s = q_mul(a, a);
      return ENTRY_BITS'(q_mul(s, q_root(s, 5)));
   endfunction

   // Encode curve point: 1.055 * x ^ (1/2.4) - 0.055, floored at zero.
   function automatic entry_type enc_entry(input wide_type x);
      wide_type off;
      wide_type p;
      wide_type e;
      off = (64'd55 * ONE_Q30) / 64'd1000;
      p   = q_mul(q_root(x, 4), q_root(q_root(x, 2), 3));
      e   = (p * 64'd1055) / 64'd1000;
      return (e >= off) ? ENTRY_BITS'(e - off) : '0;
   endfunction

endpackage

@@ src/srgbtc_req_if.sv @@
// Pixel request channel: valid/ready handshake with direction and three input channels.
interface srgbtc_req_if
   import srgbtc_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic                    func;
   logic [CHANNEL_BITS-1:0] red_in;
   logic [CHANNEL_BITS-1:0] green_in;
   logic [CHANNEL_BITS-1:0] blue_in;

   modport source (output valid, func, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

@@ src/srgbtc_rsp_if.sv @@
// Pixel response channel: valid/ready handshake with three converted channels.
interface srgbtc_rsp_if
   import srgbtc_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red_out;
   logic [CHANNEL_BITS-1:0] green_out;
   logic [CHANNEL_BITS-1:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

@@ src/srgbtc_lane.sv @@
// Four-stage datapath converting one color channel through the sRGB transfer curve.
module srgbtc_lane
   import srgbtc_pkg::*;
#(
   parameter int CHANNEL_BITS        = CHANNEL_BITS_DEF,
   parameter int CURVE_TABLE_ENTRIES = CURVE_TABLE_ENTRIES_DEF
) (
   input  logic                    clock,
   input  logic                    adv,
   input  logic                    func,
   input  logic [CHANNEL_BITS-1:0] chan_in,
   output logic [CHANNEL_BITS-1:0] chan_out
);

   localparam int F  = CHANNEL_BITS;
   localparam int EW = ENTRY_BITS;
   localparam int KW = $clog2(CURVE_TABLE_ENTRIES);
   localparam int TW = F + KW;
   // Numerator of the linear segment, valid only while that segment is chosen.
   localparam int VW = F + 3;
   localparam int MW = VW - 6;
   localparam int XW = F + 11;

   localparam wide_type LinThresh = (64'd4045 << F) / 64'd100000;
   localparam wide_type EncThresh = (64'd31308 << F) / 64'd10000000;
   localparam wide_type LinRecip  = (64'd1 << VW) / 64'd1292;
   localparam wide_type EncRecip  = (64'd1 << VW) / 64'd100;
   localparam wide_type RoundHalf = 64'd1 << (29 - F);

   // Curve tables, split into base point and non-negative step per segment.
   entry_type lin_base  [CURVE_TABLE_ENTRIES];
   entry_type lin_delta [CURVE_TABLE_ENTRIES];
   entry_type enc_base  [CURVE_TABLE_ENTRIES];
   entry_type enc_delta [CURVE_TABLE_ENTRIES];

   for (genvar gk = 0; gk < CURVE_TABLE_ENTRIES; gk++) begin : g_rom
      localparam wide_type  X0   = (wide_type'(gk) << 30) / CURVE_TABLE_ENTRIES;
      localparam wide_type  X1   = (wide_type'(gk + 1) << 30) / CURVE_TABLE_ENTRIES;
      localparam entry_type Lin0 = lin_entry(X0);
      localparam entry_type Lin1 = lin_entry(X1);
      localparam entry_type Enc0 = enc_entry(X0);
      localparam entry_type Enc1 = enc_entry(X1);
      assign lin_base[gk]  = Lin0;
      assign lin_delta[gk] = (Lin1 > Lin0) ? entry_type'(Lin1 - Lin0) : '0;
      assign enc_base[gk]  = Enc0;
      assign enc_delta[gk] = (Enc1 > Enc0) ? entry_type'(Enc1 - Enc0) : '0;
   end

   // Stage A: table position, segment choice, linear numerator.
   logic [TW-1:0] a_t_ff, a_t_in;
   logic [VW-1:0] a_v_ff, a_v_in;
   logic          a_small_ff, a_small_in;
   logic          a_func_ff;
   logic [XW-1:0] vlin_full;
   logic [XW-1:0] venc_full;

   always_comb begin
      vlin_full = XW'(chan_in) * XW'(100) + XW'(646);
      venc_full = XW'(chan_in) * XW'(1292) + XW'(50);
      a_t_in    = TW'(chan_in) * TW'(CURVE_TABLE_ENTRIES);
      if (func == FUNC_TO_SRGB) begin
         a_small_in = wide_type'(chan_in) <= EncThresh;
         a_v_in     = venc_full[VW-1:0];
      end else begin
         a_small_in = wide_type'(chan_in) <= LinThresh;
         a_v_in     = vlin_full[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_t_ff     <= a_t_in;
         a_v_ff     <= a_v_in;
         a_small_ff <= a_small_in;
         a_func_ff  <= func;
      end
   end

   // Stage B: table read and reciprocal estimate of the quotient.
   logic [KW-1:0]    k_idx;
   entry_type        b_base_ff, b_base_in;
   entry_type        b_delta_ff, b_delta_in;
   logic [F-1:0]     b_frac_ff;
   logic [MW-1:0]    b_q0_ff, b_q0_in;
   logic [VW-1:0]    b_v_ff;
   logic             b_small_ff;
   logic             b_func_ff;
   logic [MW-1:0]    recip;
   logic [VW+MW-1:0] qprod;

   always_comb begin
      k_idx = a_t_ff[F +: KW];
      if (a_func_ff == FUNC_TO_SRGB) begin
         b_base_in  = enc_base[k_idx];
         b_delta_in = enc_delta[k_idx];
         recip      = MW'(EncRecip);
      end else begin
         b_base_in  = lin_base[k_idx];
         b_delta_in = lin_delta[k_idx];
         recip      = MW'(LinRecip);
      end
      qprod   = (VW+MW)'(a_v_ff) * (VW+MW)'(recip);
      b_q0_in = qprod[VW +: MW];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_base_ff  <= b_base_in;
         b_delta_ff <= b_delta_in;
         b_frac_ff  <= a_t_ff[F-1:0];
         b_q0_ff    <= b_q0_in;
         b_v_ff     <= a_v_ff;
         b_small_ff <= a_small_ff;
         b_func_ff  <= a_func_ff;
      end
   end

   // Stage C: interpolation product and quotient correction.
   entry_type       c_base_ff;
   entry_type       c_step_ff, c_step_in;
   logic [F-1:0]    c_lin_ff, c_lin_in;
   logic            c_small_ff;
   logic [VW-1:0]   divisor;
   logic [VW-1:0]   qd;
   logic [VW-1:0]   rem;
   logic            corr;
   logic [EW+F-1:0] sprod;

   always_comb begin
      divisor   = (b_func_ff == FUNC_TO_SRGB) ? VW'(100) : VW'(1292);
      qd        = VW'(VW'(b_q0_ff) * divisor);
      rem       = b_v_ff - qd;
      corr      = rem >= divisor;
      c_lin_in  = F'({1'b0, b_q0_ff} + (MW+1)'(corr));
      sprod     = (EW+F)'(b_delta_ff) * (EW+F)'(b_frac_ff);
      c_step_in = sprod[F +: EW];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_base_ff  <= b_base_ff;
         c_step_ff  <= c_step_in;
         c_lin_ff   <= c_lin_in;
         c_small_ff <= b_small_ff;
      end
   end

   // Stage D: round the curve value to the channel format, saturate, select.
   logic [EW+1:0] y_sum;
   logic [F+2:0]  y_round;
   logic [F-1:0]  curve;
   logic [F-1:0]  d_out_ff, d_out_in;

   always_comb begin
      y_sum   = (EW+2)'(c_base_ff) + (EW+2)'(c_step_ff) + (EW+2)'(RoundHalf);
      y_round = y_sum[EW+1 : 30-F];
      curve   = (y_round > (F+3)'({F{1'b1}})) ? {F{1'b1}} : y_round[F-1:0];
      d_out_in = c_small_ff ? c_lin_ff : curve;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_out_ff <= d_out_in;
      end
   end

   assign chan_out = d_out_ff;

endmodule

@@ src/srgb_transfer_convert_core.sv @@
// Top level of the sRGB transfer converter: handshake, valid pipeline and three channel lanes.
// Path: an accepted beat is registered in stages A, B, C and D in turn; stage D drives rsp.
// Throughput: one pixel per clock while rsp is not stalled; the four register stages are fully pipelined.
// Backpressure: the whole pipeline holds while the response register is full and not taken.
// Reset: synchronous, active high; it clears the stage valid bits, payload is not reset.
// No clearing pass is needed after reset; the curve tables are constant logic.
module srgb_transfer_convert_core
   import srgbtc_pkg::*;
#(
   parameter int CHANNEL_BITS        = CHANNEL_BITS_DEF,
   parameter int CURVE_TABLE_ENTRIES = CURVE_TABLE_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   srgbtc_req_if.sink   req_bus,
   srgbtc_rsp_if.source rsp_bus
);

   localparam int Stages = 4;

   // One valid bit per register stage; the last one is the response register.
   logic [Stages-1:0] vld_ff, vld_in;
   logic              adv;

   // The pipeline moves whenever the response register is empty or being drained.
   // A beat in the response register that is not taken freezes every stage.
   assign adv           = !vld_ff[Stages-1] || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign rsp_bus.valid = vld_ff[Stages-1];

   always_comb begin
      if (adv) begin
         vld_in = {vld_ff[Stages-2:0], req_bus.valid};
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Each lane carries one color channel; they share the direction and advance together.
   srgbtc_lane #(
      .CHANNEL_BITS        (CHANNEL_BITS),
      .CURVE_TABLE_ENTRIES (CURVE_TABLE_ENTRIES)
   ) u_red (
      .clock    (clock),
      .adv      (adv),
      .func     (req_bus.func),
      .chan_in  (req_bus.red_in),
      .chan_out (rsp_bus.red_out)
   );

   srgbtc_lane #(
      .CHANNEL_BITS        (CHANNEL_BITS),
      .CURVE_TABLE_ENTRIES (CURVE_TABLE_ENTRIES)
   ) u_green (
      .clock    (clock),
      .adv      (adv),
      .func     (req_bus.func),
      .chan_in  (req_bus.green_in),
      .chan_out (rsp_bus.green_out)
   );

   srgbtc_lane #(
      .CHANNEL_BITS        (CHANNEL_BITS),
      .CURVE_TABLE_ENTRIES (CURVE_TABLE_ENTRIES)
   ) u_blue (
      .clock    (clock),
      .adv      (adv),
      .func     (req_bus.func),
      .chan_in  (req_bus.blue_in),
      .chan_out (rsp_bus.blue_out)
   );

   // A stall must freeze every stage so that no beat is lost or duplicated.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!adv && !reset) |=> $stable(vld_ff))
      else $error("pipeline valid bits changed during a stall");

   // When the pipeline advances, every valid bit moves one stage forward.
   a_shift: assert property (@(posedge clock) disable iff (reset)
      (adv && !reset) |=> (vld_ff[Stages-1:1] == $past(vld_ff[Stages-2:0])))
      else $error("valid bits did not shift with the pipeline");

   // An accepted beat always occupies the first stage on the next cycle.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && adv && !reset) |=> vld_ff[0])
      else $error("accepted beat did not enter the first stage");

endmodule
